FILE: sv/svr_pkg.sv
// shared types and constants of the skinned vertex repacker
// no dependencies
`default_nettype none

package svr_pkg;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NONFIN   = 2'd1;
  localparam logic [1:0] STAT_BONE_OOR = 2'd2;

  localparam logic [31:0] FP_ONE   = 32'h3f80_0000;
  localparam logic [31:0] FP_INF   = 32'h7f80_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [7:0]  EXP_ALL  = 8'hff;

  localparam int NUM_BONES     = 4;
  localparam int ADD_STAGES    = 3;
  localparam int DIV_STEPS     = 7;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_Q_W       = DIV_STEPS * DIV_STEP_BITS;
  localparam int PIPE_DEPTH    = 1 + ADD_STAGES + 1 + DIV_STEPS + 1;

  typedef logic [NUM_BONES-1:0][31:0] word4_t;

  typedef struct packed {
    logic [63:0] position_xy;
    logic [31:0] position_z;
    logic [63:0] normal_xy;
    logic [31:0] normal_z;
    logic [63:0] texcoord_uv;
    word4_t      bones;
    word4_t      weights;
  } vtx_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] position_xy;
    logic [31:0] position_z;
    logic [63:0] texcoord_uv;
    logic [23:0] packed_normal;
    word4_t      bones;
  } meta_t;

  typedef struct packed {
    meta_t  meta;
    word4_t weights;
  } vtx_out_t;

endpackage

`default_nettype wire

FILE: sv/svr_if.sv
// request and result channels of the skinned vertex repacker
// no dependencies
`default_nettype none

interface svr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] position_xy;
  logic [31:0] position_z;
  logic [63:0] normal_xy;
  logic [31:0] normal_z;
  logic [63:0] texcoord_uv;
  logic [63:0] bone_pair_lo;
  logic [63:0] bone_pair_hi;
  logic [63:0] weight_pair_lo;
  logic [63:0] weight_pair_hi;

  modport source (
    output valid, position_xy, position_z, normal_xy, normal_z, texcoord_uv,
           bone_pair_lo, bone_pair_hi, weight_pair_lo, weight_pair_hi,
    input  ready
  );
  modport sink (
    input  valid, position_xy, position_z, normal_xy, normal_z, texcoord_uv,
           bone_pair_lo, bone_pair_hi, weight_pair_lo, weight_pair_hi,
    output ready
  );
endinterface

interface svr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_position_xy;
  logic [31:0] out_position_z;
  logic [63:0] out_texcoord_uv;
  logic [23:0] packed_normal;
  logic [63:0] skin_bones_lo;
  logic [63:0] skin_bones_hi;
  logic [63:0] skin_weights_lo;
  logic [63:0] skin_weights_hi;

  modport source (
    output valid, status, out_position_xy, out_position_z, out_texcoord_uv,
           packed_normal, skin_bones_lo, skin_bones_hi, skin_weights_lo,
           skin_weights_hi,
    input  ready
  );
  modport sink (
    input  valid, status, out_position_xy, out_position_z, out_texcoord_uv,
           packed_normal, skin_bones_lo, skin_bones_hi, skin_weights_lo,
           skin_weights_hi,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/svr_front.sv
// first stage: finite checks, bone filtering, range check and normal packing
// depends on svr_pkg
`default_nettype none

module svr_front (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [15:0]      bone_lim_i,
  input  wire svr_pkg::vtx_in_t vtx_i,
  output svr_pkg::meta_t        meta_o,
  output svr_pkg::word4_t       weights_o
);

  function automatic logic [7:0] normal_byte(input logic [31:0] c);
    logic [7:0]  e;
    logic [30:0] p;
    logic [23:0] keep;
    logic        g;
    logic        st;
    logic [24:0] r;
    logic [24:0] sh;
    logic [7:0]  mag;
    begin
      e    = c[30:23];
      p    = {7'd0, 1'b1, c[22:0]} * 31'd127;
      keep = '0;
      g    = 1'b0;
      st   = 1'b0;
      r    = '0;
      sh   = '0;
      mag  = '0;
      if (e >= 8'd127) begin
        mag = 8'd127;
      end else if (e >= 8'd120) begin
        if (p[30]) begin
          keep = p[30:7];
          g    = p[6];
          st   = |p[5:0];
          r    = {1'b0, keep} + 25'(g & (st | keep[0]));
          sh   = r >> (8'd143 - e);
        end else begin
          keep = p[29:6];
          g    = p[5];
          st   = |p[4:0];
          r    = {1'b0, keep} + 25'(g & (st | keep[0]));
          sh   = r >> (8'd144 - e);
        end
        mag = sh[7:0];
      end
      normal_byte = c[31] ? (8'd0 - mag) : mag;
    end
  endfunction

  logic            nonfin;
  logic [3:0]      keep;
  logic [3:0]      oor;
  logic [1:0]      status;
  svr_pkg::meta_t  meta_d;
  svr_pkg::word4_t w_d;

  always_comb begin
    nonfin = (vtx_i.position_xy[30:23] == svr_pkg::EXP_ALL)
           | (vtx_i.position_xy[62:55] == svr_pkg::EXP_ALL)
           | (vtx_i.position_z[30:23]  == svr_pkg::EXP_ALL)
           | (vtx_i.normal_xy[30:23]   == svr_pkg::EXP_ALL)
           | (vtx_i.normal_xy[62:55]   == svr_pkg::EXP_ALL)
           | (vtx_i.normal_z[30:23]    == svr_pkg::EXP_ALL)
           | (vtx_i.texcoord_uv[30:23] == svr_pkg::EXP_ALL)
           | (vtx_i.texcoord_uv[62:55] == svr_pkg::EXP_ALL);
    for (int i = 0; i < svr_pkg::NUM_BONES; i++) begin
      keep[i] = !vtx_i.bones[i][31] && !vtx_i.weights[i][31]
             && (vtx_i.weights[i][30:23] != svr_pkg::EXP_ALL)
             && (vtx_i.weights[i][30:0] != 31'd0);
      oor[i]  = keep[i] && (vtx_i.bones[i] >= {16'd0, bone_lim_i});
      w_d[i]  = keep[i] ? vtx_i.weights[i] : 32'd0;
    end
    if (nonfin) begin
      status = svr_pkg::STAT_NONFIN;
    end else if (|oor) begin
      status = svr_pkg::STAT_BONE_OOR;
    end else begin
      status = svr_pkg::STAT_OK;
    end
    meta_d = '0;
    meta_d.status = status;
    if (status == svr_pkg::STAT_OK) begin
      meta_d.position_xy   = vtx_i.position_xy;
      meta_d.position_z    = vtx_i.position_z ^ svr_pkg::SIGN_BIT;
      meta_d.texcoord_uv   = vtx_i.texcoord_uv;
      meta_d.packed_normal = {normal_byte(vtx_i.normal_z ^ svr_pkg::SIGN_BIT),
                              normal_byte(vtx_i.normal_xy[63:32]),
                              normal_byte(vtx_i.normal_xy[31:0])};
      for (int i = 0; i < svr_pkg::NUM_BONES; i++) begin
        meta_d.bones[i] = keep[i] ? (vtx_i.bones[i] + 32'd1) : 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_o    <= meta_d;
      weights_o <= w_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/svr_wsum.sv
// three-stage chain of single-precision adds for non-negative weights
// depends on svr_pkg
`default_nettype none

module svr_wsum (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire svr_pkg::word4_t weights_i,
  output svr_pkg::word4_t      weights_o,
  output logic [31:0]          sum_o
);

  // round-to-nearest-even add of two non-negative operands
  function automatic logic [31:0] fadd_pos(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [26:0] x;
    logic [26:0] al;
    logic        st;
    logic [27:0] s;
    logic [8:0]  e;
    logic [23:0] sig;
    logic        up;
    logic [31:0] res;
    begin
      if (a[30:0] >= b[30:0]) begin
        big = a;
        sml = b;
      end else begin
        big = b;
        sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mb = {big[30:23] != 8'd0, big[22:0]};
      ms = {sml[30:23] != 8'd0, sml[22:0]};
      d  = eb - es;
      x  = {ms, 3'b000};
      if (d >= 8'd27) begin
        al = '0;
        st = (ms != 24'd0);
      end else begin
        al = x >> d;
        st = ((x & ((27'd1 << d) - 27'd1)) != 27'd0);
      end
      s = {1'b0, mb, 3'b000} + {1'b0, al[26:1], al[0] | st};
      e = {1'b0, eb};
      if (s[27]) begin
        s = {1'b0, s[27:2], s[1] | s[0]};
        e = e + 9'd1;
      end
      sig = s[26:3];
      up  = s[2] & (s[1] | s[0] | sig[0]);
      res = {e - 9'd1, 23'd0} + {8'd0, sig} + 32'(up);
      if ((big[30:23] == svr_pkg::EXP_ALL) || (res[31:23] >= 9'd255)) begin
        res = svr_pkg::FP_INF;
      end
      fadd_pos = res;
    end
  endfunction

  svr_pkg::word4_t w_q [svr_pkg::ADD_STAGES];
  logic [31:0]     s_q [svr_pkg::ADD_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= weights_i;
      s_q[0] <= fadd_pos(weights_i[0], weights_i[1]);
      for (int k = 1; k < svr_pkg::ADD_STAGES; k++) begin
        w_q[k] <= w_q[k-1];
        s_q[k] <= fadd_pos(s_q[k-1], w_q[k-1][k+1]);
      end
    end
  end

  assign weights_o = w_q[svr_pkg::ADD_STAGES-1];
  assign sum_o     = s_q[svr_pkg::ADD_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/svr_div.sv
// one lane of a pipelined radix-2 divider for a <= b, a >= 0, b > 0
// prep stage, DIV_STEPS stages of DIV_STEP_BITS bits, rounding stage; needs svr_pkg
`default_nettype none

module svr_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      q_o
);

  localparam int NS = svr_pkg::DIV_STEPS;
  localparam int QW = svr_pkg::DIV_Q_W;

  function automatic logic [23:0] norm_sig(input logic [31:0] x, output logic [10:0] ex);
    logic [23:0] m;
    logic [4:0]  lz;
    logic [7:0]  f;
    begin
      f  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      m  = {x[30:23] != 8'd0, x[22:0]};
      lz = '0;
      for (int i = 0; i < 24; i++) begin
        if (m[i]) lz = 5'(23 - i);
      end
      ex       = {3'd0, f} - {6'd0, lz};
      norm_sig = m << lz;
    end
  endfunction

  logic [23:0] ma;
  logic [23:0] mbn;
  logic [10:0] ea;
  logic [10:0] eb;
  logic [24:0] r_d;
  logic [10:0] e_d;

  always_comb begin
    ma  = norm_sig(a_i, ea);
    mbn = norm_sig(b_i, eb);
    e_d = ea - eb + 11'd127;
    if (ma < mbn) begin
      r_d = {ma, 1'b0};
      e_d = e_d - 11'd1;
    end else begin
      r_d = {1'b0, ma};
    end
  end

  logic [24:0]   r_q    [NS+1];
  logic [QW-1:0] q_q    [NS+1];
  logic [23:0]   mb_q   [NS+1];
  logic [10:0]   e_q    [NS+1];
  logic          zero_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= r_d;
      q_q[0]    <= '0;
      mb_q[0]   <= mbn;
      e_q[0]    <= e_d;
      zero_q[0] <= (a_i[30:0] == 31'd0);
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [24:0]   r_n;
    logic [QW-1:0] q_n;
    always_comb begin
      r_n = r_q[k-1];
      q_n = q_q[k-1];
      for (int j = 0; j < svr_pkg::DIV_STEP_BITS; j++) begin
        if (r_n >= {1'b0, mb_q[k-1]}) begin
          r_n = r_n - {1'b0, mb_q[k-1]};
          q_n = {q_n[QW-2:0], 1'b1};
        end else begin
          q_n = {q_n[QW-2:0], 1'b0};
        end
        r_n = {r_n[23:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_n;
        q_q[k]    <= q_n;
        mb_q[k]   <= mb_q[k-1];
        e_q[k]    <= e_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  logic [25:0] t;
  logic [25:0] ts;
  logic [10:0] nsh;
  logic [4:0]  sh;
  logic [7:0]  ef;
  logic        st2;
  logic [23:0] sig;
  logic        up;
  logic [31:0] res;

  always_comb begin
    t   = {q_q[NS][QW-1:QW-25], (|q_q[NS][QW-26:0]) | (r_q[NS] != 25'd0)};
    nsh = 11'd1 - e_q[NS];
    if (!e_q[NS][10] && (e_q[NS] != 11'd0)) begin
      sh = '0;
      ef = e_q[NS][7:0];
    end else begin
      sh = (nsh > 11'd26) ? 5'd26 : nsh[4:0];
      ef = 8'd1;
    end
    ts  = t >> sh;
    st2 = ((t & ((26'd1 << sh) - 26'd1)) != 26'd0);
    sig = ts[25:2];
    up  = ts[1] & (ts[0] | st2 | sig[0]);
    res = {1'b0, ef - 8'd1, 23'd0} + {8'd0, sig} + 32'(up);
    if (zero_q[NS]) res = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/skinned_vertex_repacker_top.sv
// skinned vertex repacker: one source vertex in, one converted vertex out
// Usage: drive vertices on in_i (valid/ready), take results from out_o
// (valid/ready); write the bone limit through cfg_we_i/cfg_wdata_i while idle.
// A request accepted at a clock edge passes through 13 pipeline registers
// (the first loaded at the accepting edge) and then the output buffer
// before its result shows on out_o.
// Throughput: one vertex per cycle while the output buffer is not full, set by
// the fully pipelined weight adder chain (3 stages) and the four divider lanes
// (9 stages, 4 quotient bits per step stage).
// Reset clears the bone limit to zero, empties the pipeline and the output
// buffer; in_i.ready is high right after reset.
// A 2-entry output buffer sits between the pipeline and out_o. When the
// receiver stalls and the buffer fills, the whole pipeline holds in place and
// in_i.ready drops; nothing in flight is lost or repeated.
// Depends on svr_pkg, svr_if, svr_front, svr_wsum, svr_div.
`default_nettype none

module skinned_vertex_repacker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  svr_in_if.sink           in_i,
  svr_out_if.source        out_o
);

  localparam int PD = svr_pkg::PIPE_DEPTH;
  localparam int DEGEN_IDX = svr_pkg::ADD_STAGES;

  logic [15:0] bone_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_lim_q <= '0;
    end else if (cfg_we_i) begin
      bone_lim_q <= cfg_wdata_i;
    end
  end

  logic en;
  logic full;

  assign en         = !full;
  assign in_i.ready = en;

  svr_pkg::vtx_in_t vtx;
  always_comb begin
    vtx.position_xy = in_i.position_xy;
    vtx.position_z  = in_i.position_z;
    vtx.normal_xy   = in_i.normal_xy;
    vtx.normal_z    = in_i.normal_z;
    vtx.texcoord_uv = in_i.texcoord_uv;
    vtx.bones       = {in_i.bone_pair_hi, in_i.bone_pair_lo};
    vtx.weights     = {in_i.weight_pair_hi, in_i.weight_pair_lo};
  end

  // valid bits for every stage
  logic [PD-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PD-2:0], in_i.valid};
    end
  end

  svr_pkg::meta_t  meta_s1;
  svr_pkg::word4_t w_s1;

  svr_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .bone_lim_i(bone_lim_q),
    .vtx_i     (vtx),
    .meta_o    (meta_s1),
    .weights_o (w_s1)
  );

  svr_pkg::word4_t w_sum;
  logic [31:0]     sum;

  svr_wsum u_wsum (
    .clk_i    (clk_i),
    .en_i     (en),
    .weights_i(w_s1),
    .weights_o(w_sum),
    .sum_o    (sum)
  );

  logic degen;
  assign degen = (sum[30:23] == svr_pkg::EXP_ALL) || (sum[30:0] == 31'd0);

  svr_pkg::word4_t wq;
  for (genvar i = 0; i < svr_pkg::NUM_BONES; i++) begin : g_lane
    logic [31:0] a;
    assign a = degen ? ((i == 0) ? svr_pkg::FP_ONE : 32'd0) : w_sum[i];
    svr_div u_div (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (a),
      .b_i  (degen ? svr_pkg::FP_ONE : sum),
      .q_o  (wq[i])
    );
  end

  // side data for stages 2 .. PD
  svr_pkg::meta_t meta_q [PD-1];
  svr_pkg::meta_t meta_degen;

  always_comb begin
    meta_degen = meta_q[DEGEN_IDX-1];
    if (degen) begin
      meta_degen.bones = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_s1;
      for (int k = 1; k < PD - 1; k++) begin
        meta_q[k] <= (k == DEGEN_IDX) ? meta_degen : meta_q[k-1];
      end
    end
  end

  // output buffer
  svr_pkg::vtx_out_t buf_q [2];
  svr_pkg::vtx_out_t push_data;
  logic [1:0] cnt_q;
  logic       wptr_q;
  logic       rptr_q;
  logic       push;
  logic       pop;

  always_comb begin
    push_data.meta    = meta_q[PD-2];
    push_data.weights = (meta_q[PD-2].status == svr_pkg::STAT_OK) ? wq : '0;
  end

  assign full = (cnt_q == 2'd2);
  assign push = en && vld_q[PD-1];
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= push_data;
    end
  end

  svr_pkg::vtx_out_t head;
  assign head = buf_q[rptr_q];

  assign out_o.valid           = (cnt_q != 2'd0);
  assign out_o.status          = head.meta.status;
  assign out_o.out_position_xy = head.meta.position_xy;
  assign out_o.out_position_z  = head.meta.position_z;
  assign out_o.out_texcoord_uv = head.meta.texcoord_uv;
  assign out_o.packed_normal   = head.meta.packed_normal;
  assign out_o.skin_bones_lo   = {head.meta.bones[1], head.meta.bones[0]};
  assign out_o.skin_bones_hi   = {head.meta.bones[3], head.meta.bones[2]};
  assign out_o.skin_weights_lo = {head.weights[1], head.weights[0]};
  assign out_o.skin_weights_hi = {head.weights[3], head.weights[2]};

endmodule

`default_nettype wire
